// ===== rtl/core/tcce_pkg.sv =====
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // control bytes
  localparam logic [7:0] CHAR_TAB = 8'd9;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_CR  = 8'd13;

  // pending scroll count saturates here
  localparam int PendW = 4;
  localparam logic [PendW-1:0] MAX_PENDING = 4'd8;

  // result kinds
  localparam logic KIND_SCROLL = 1'b0;
  localparam logic KIND_DRAW   = 1'b1;

  // register byte addresses
  localparam int AddrW = 4;
  localparam logic [AddrW-1:0] REG_SCROLL_MODE  = 4'h0;
  localparam logic [AddrW-1:0] REG_CONTINUOUS   = 4'h4;
  localparam logic [AddrW-1:0] REG_START_COLUMN = 4'h8;
  localparam logic [AddrW-1:0] REG_START_ROW    = 4'hC;

  typedef struct packed {
    logic [7:0] char_code;
    logic       string_start;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] pixel_column;
    logic [2:0] page;
    logic [7:0] glyph_code;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       scroll_mode;
    logic       continuous;
    logic [4:0] start_column;
    logic [2:0] start_row;
  } cfg_t;

  typedef struct packed {
    logic load;         // take an input word, reload cursor if asked
    logic exec_ctrl;    // apply return, line feed or tab
    logic emit_scroll;  // put one scroll word in the output register
    logic emit_draw;    // put the draw word in the output register
  } cmd_t;

  typedef struct packed {
    logic is_ctrl;
    logic scroll_due;
  } stat_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

// ===== rtl/core/text_console_cursor_engine_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Character cursor of a text console: turns characters into scroll and draw
// words.
// ----------------------------------------------------------------------------
//  channel | handshake                         | word
//  --------+-----------------------------------+------------------------------
//  in      | in_valid_i / in_ready_o           | in_data_i  (in_item_t)
//  out     | out_valid_o / out_ready_i         | out_data_o (out_item_t)
//  config  | psel, penable, pwrite, pready = 1 | paddr, pwdata, prdata
//
//  a character is taken in the idle state and decoded in the exec state of the
//  sequencer; each pending scroll puts one scroll word ahead of the draw word.
//  the single output register sets the pace under stall: the sequencer waits
//  in its decode state until that register is free, the next word is taken
//  while the last result still waits there.
//  reset: cursor at column 0, row 0, scroll mode on; no clearing pass.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit import tcce_pkg::*; #(
  parameter int TEXT_COLUMNS = 21,
  parameter int TEXT_ROWS    = 8,
  parameter int GLYPH_WIDTH  = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;
  logic  wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scroll_mode  <= 1'b1;
      cfg_q.continuous   <= 1'b0;
      cfg_q.start_column <= '0;
      cfg_q.start_row    <= '0;
    end else if (wr_en) begin
      case (paddr)
        REG_SCROLL_MODE:  cfg_q.scroll_mode  <= pwdata[0];
        REG_CONTINUOUS:   cfg_q.continuous   <= pwdata[0];
        REG_START_COLUMN: cfg_q.start_column <= pwdata[4:0];
        REG_START_ROW:    cfg_q.start_row    <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr)
      REG_SCROLL_MODE:  prdata[0]   = cfg_q.scroll_mode;
      REG_CONTINUOUS:   prdata[0]   = cfg_q.continuous;
      REG_START_COLUMN: prdata[4:0] = cfg_q.start_column;
      REG_START_ROW:    prdata[2:0] = cfg_q.start_row;
      default: ;
    endcase
  end

  tcce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tcce_datapath #(
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS),
    .GLYPH_WIDTH  (GLYPH_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

  // one character at a time: a taken word blocks the next while it is decoded
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // only the draw word closes a character
  a_last_on_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.kind == KIND_DRAW) == out_data_o.last))
    else $error("last flag does not match word kind");

  // a new result is only loaded into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_scroll || cmd.emit_draw) |-> (!out_valid_o || out_ready_i))
    else $error("output word overwritten before it was taken");

endmodule

// ===== rtl/core/tcce_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcce_ctrl
// Sequencer: takes one character, then drives scroll and draw words out.
// ----------------------------------------------------------------------------
module tcce_ctrl import tcce_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat_i.is_ctrl || (slot_free && !stat_i.scroll_due)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EXEC: begin
        if (stat_i.is_ctrl) begin
          cmd_o.exec_ctrl = 1'b1;
        end else if (slot_free) begin
          cmd_o.emit_scroll = stat_i.scroll_due;
          cmd_o.emit_draw   = !stat_i.scroll_due;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.emit_scroll || cmd_o.emit_draw) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/tcce_datapath.sv =====
// ----------------------------------------------------------------------------
// tcce_datapath
// Cursor state, pending scroll count and the output word register.
// ----------------------------------------------------------------------------
module tcce_datapath import tcce_pkg::*; #(
  parameter int TEXT_COLUMNS = 21,
  parameter int TEXT_ROWS    = 8,
  parameter int GLYPH_WIDTH  = 6
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  in_item_t  in_data_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output out_item_t out_data_o
);

  localparam int ColW  = $clog2(TEXT_COLUMNS);
  localparam int RowW  = $clog2(TEXT_ROWS + 1);
  localparam int PixW  = ColW + 4;
  localparam int RowXW = RowW + 3;

  localparam logic [ColW:0]   LastCol  = (ColW+1)'(TEXT_COLUMNS - 1);
  localparam logic [RowW-1:0] LastRow  = RowW'(TEXT_ROWS - 1);
  localparam logic [RowW-1:0] RowLimit = RowW'(TEXT_ROWS);

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             armed_q, armed_d;
  logic [PendW-1:0] pend_q, pend_d;
  logic [7:0]       char_q;
  out_item_t        out_q, out_d;

  logic [ColW-1:0]  reload_col;
  logic [RowW-1:0]  reload_row;
  logic [RowW-1:0]  adv_row;
  logic [PendW-1:0] adv_pend;
  logic [RowW:0]    row_inc;
  logic [ColW:0]    col_inc;
  logic [ColW:0]    tab_stop;
  logic [PixW-1:0]  pix_full;
  logic [RowW-1:0]  page_clamp;
  logic [RowXW-1:0] page_x;

  // clamped start position
  assign reload_col = (cfg_i.start_column > 5'(TEXT_COLUMNS - 1))
                    ? ColW'(TEXT_COLUMNS - 1) : ColW'(cfg_i.start_column);
  assign reload_row = ({2'b00, cfg_i.start_row} > 5'(TEXT_ROWS - 1))
                    ? LastRow : RowW'({2'b00, cfg_i.start_row});

  // one row down, with scroll counting past the bottom
  always_comb begin
    row_inc  = {1'b0, row_q} + 1'b1;
    adv_pend = pend_q;
    if (cfg_i.scroll_mode && (row_inc > {1'b0, LastRow}) && (pend_q < MAX_PENDING)) begin
      adv_pend = pend_q + 1'b1;
    end
    adv_row = (row_inc > {1'b0, RowLimit}) ? RowLimit : row_inc[RowW-1:0];
  end

  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign tab_stop = col_inc | (ColW+1)'(3);

  assign pix_full   = PixW'(col_q) * PixW'(GLYPH_WIDTH);
  assign page_clamp = (row_q > LastRow) ? LastRow : row_q;
  assign page_x     = RowXW'(page_clamp);

  assign stat_o.is_ctrl    = (char_q == CHAR_CR) || (char_q == CHAR_LF) ||
                             (char_q == CHAR_TAB);
  assign stat_o.scroll_due = cfg_i.scroll_mode && (pend_q != '0);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    armed_d = armed_q;
    pend_d  = pend_q;
    out_d   = out_q;
    if (cmd_i.load && in_data_i.string_start && !cfg_i.continuous) begin
      col_d = reload_col;
      row_d = reload_row;
    end
    if (cmd_i.exec_ctrl) begin
      case (char_q)
        CHAR_CR: col_d = '0;
        CHAR_LF: begin
          if (armed_q) begin
            row_d  = adv_row;
            pend_d = adv_pend;
          end
          armed_d = 1'b1;
        end
        CHAR_TAB: begin
          armed_d = 1'b1;
          if (tab_stop >= LastCol) begin
            col_d  = '0;
            row_d  = adv_row;
            pend_d = adv_pend;
          end else begin
            col_d = tab_stop[ColW-1:0];
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.emit_scroll) begin
      pend_d = pend_q - 1'b1;
      out_d  = '0;
      out_d.kind = KIND_SCROLL;
    end
    if (cmd_i.emit_draw) begin
      out_d.kind         = KIND_DRAW;
      out_d.pixel_column = pix_full[6:0];
      out_d.page         = page_x[2:0];
      out_d.glyph_code   = char_q;
      out_d.last         = 1'b1;
      armed_d            = 1'b1;
      if (col_inc >= LastCol + 1'b1) begin
        col_d   = '0;
        armed_d = 1'b0;
        row_d   = adv_row;
        pend_d  = adv_pend;
      end else begin
        col_d = col_inc[ColW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      armed_q <= 1'b1;
      pend_q  <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      armed_q <= armed_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) char_q <= in_data_i.char_code;
    out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

// ===== test/tcce_cursor_checker.sv =====
// ----------------------------------------------------------------------------
// tcce_cursor_checker
// Watches the character, result and register ports of the cursor engine,
// tracks the cursor on its own and compares every result word in order.
// ----------------------------------------------------------------------------
module tcce_cursor_checker import tcce_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  in_item_t         in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  out_item_t        out_data_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic             pready_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [31:0]      pwdata_i,
  output int               mismatch_count_o,
  output int               words_due_o
);

  localparam int COLS    = 21;
  localparam int ROWS    = 8;
  localparam int GLYPH_W = 6;

  cfg_t             settings;
  logic [4:0]       cursor_col;
  logic [3:0]       cursor_row;
  logic             newline_armed;
  logic [PendW-1:0] pending_scrolls;
  out_item_t        expected_words[$];

  // row advance; past the bottom in scroll mode it books one scroll
  task automatic step_row();
    if (settings.scroll_mode && int'(cursor_row) + 1 > ROWS - 1 &&
        pending_scrolls < MAX_PENDING)
      pending_scrolls = pending_scrolls + 1'b1;
    if (int'(cursor_row) < ROWS)
      cursor_row = cursor_row + 1'b1;
  endtask

  task automatic track_char(input in_item_t w);
    int        stop;
    out_item_t r;
    if (w.string_start && !settings.continuous) begin
      cursor_col = (int'(settings.start_column) > COLS - 1) ? 5'(COLS - 1)
                                                             : settings.start_column;
      cursor_row = (int'(settings.start_row) > ROWS - 1) ? 4'(ROWS - 1)
                                                          : 4'(settings.start_row);
    end
    case (w.char_code)
      CHAR_CR: cursor_col = '0;
      CHAR_LF: begin
        if (newline_armed)
          step_row();
        newline_armed = 1'b1;
      end
      CHAR_TAB: begin
        newline_armed = 1'b1;
        stop = (int'(cursor_col) + 1) | 3;
        if (stop >= COLS - 1) begin
          cursor_col = '0;
          step_row();
        end else begin
          cursor_col = 5'(stop);
        end
      end
      default: begin
        newline_armed = 1'b1;
        if (settings.scroll_mode) begin
          while (pending_scrolls != 0) begin
            r = '0;
            r.kind = KIND_SCROLL;
            expected_words.push_back(r);
            pending_scrolls = pending_scrolls - 1'b1;
          end
        end
        r = '0;
        r.kind = KIND_DRAW;
        r.pixel_column = 7'(int'(cursor_col) * GLYPH_W);
        r.page = (int'(cursor_row) > ROWS - 1) ? 3'(ROWS - 1) : cursor_row[2:0];
        r.glyph_code = w.char_code;
        r.last = 1'b1;
        expected_words.push_back(r);
        // automatic wrap disarms the next line feed
        if (int'(cursor_col) + 1 >= COLS) begin
          cursor_col = '0;
          newline_armed = 1'b0;
          step_row();
        end else begin
          cursor_col = cursor_col + 1'b1;
        end
      end
    endcase
  endtask

  function automatic bit field_differs(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    bit        bad;
    if (!rst_ni) begin
      expected_words.delete();
      settings = '{scroll_mode: 1'b1, continuous: 1'b0, start_column: '0, start_row: '0};
      cursor_col = '0;
      cursor_row = '0;
      newline_armed = 1'b1;
      pending_scrolls = '0;
      mismatch_count_o = 0;
      words_due_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $display("%0t: word with none expected, got kind=%0d pix=%0d page=%0d glyph=%0d last=%0d",
                   $time, out_data_i.kind, out_data_i.pixel_column, out_data_i.page,
                   out_data_i.glyph_code, out_data_i.last);
          mismatch_count_o++;
        end else begin
          want = expected_words.pop_front();
          bad = 1'b0;
          bad |= field_differs("kind", 8'(want.kind), 8'(out_data_i.kind));
          bad |= field_differs("pixel_column", 8'(want.pixel_column),
                               8'(out_data_i.pixel_column));
          bad |= field_differs("page", 8'(want.page), 8'(out_data_i.page));
          bad |= field_differs("glyph_code", want.glyph_code, out_data_i.glyph_code);
          bad |= field_differs("last", 8'(want.last), 8'(out_data_i.last));
          if (bad)
            mismatch_count_o++;
        end
      end
      if (in_valid_i && in_ready_i)
        track_char(in_data_i);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i)
          REG_SCROLL_MODE:  settings.scroll_mode  = pwdata_i[0];
          REG_CONTINUOUS:   settings.continuous   = pwdata_i[0];
          REG_START_COLUMN: settings.start_column = pwdata_i[4:0];
          REG_START_ROW:    settings.start_row    = pwdata_i[2:0];
          default: ;
        endcase
      end
      words_due_o = expected_words.size();
    end
  end

endmodule

// ===== test/tb_text_console_cursor_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine_unit
// Drives characters and register writes into the cursor engine under random
// idling and backpressure; the checker beside the block scores the results.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_engine_unit;
  import tcce_pkg::*;

  localparam int ITEMS  = 480;
  localparam int PHASES = 8;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  int               mismatch_count;
  int               words_due;
  int               burst_left;
  bit               want_hold;
  bit               draining;

  text_console_cursor_engine_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  tcce_cursor_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatch_count),
    .words_due_o      (words_due)
  );

  always #5 clk = ~clk;

  initial begin
    #3_000_000;
    $display("tb_text_console_cursor_engine_unit: done, errors");
    $finish;
  end

  // receiver: spans of always ready, coin flip, or mostly stalled
  initial begin
    int mode;
    int span;
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(negedge clk);
        if (want_hold && !held) begin
          // long hold-off so the block backs up into its input
          held = 1'b1;
          out_ready <= 1'b0;
          repeat (80) @(negedge clk);
        end else if (draining || mode == 0) begin
          out_ready <= 1'b1;
        end else if (mode == 1) begin
          out_ready <= 1'($urandom_range(0, 1));
        end else begin
          out_ready <= ($urandom_range(0, 3) == 0);
        end
      end
    end
  end

  task automatic send_word(input logic [7:0] code, input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_data <= '{char_code: code, string_start: start};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // control words give no result, so idle on after the last expected word too
  task automatic quiesce();
    in_valid <= 1'b0;
    while (words_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic reg_write(input logic [AddrW-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_mode(input bit scroll, input bit cont, input int col, input int row);
    reg_write(REG_SCROLL_MODE, 32'(scroll));
    reg_write(REG_CONTINUOUS, 32'(cont));
    reg_write(REG_START_COLUMN, 32'(col));
    reg_write(REG_START_ROW, 32'(row));
  endtask

  task automatic send_random_char();
    int         pick;
    logic [7:0] code;
    pick = $urandom_range(0, 99);
    if (pick < 14)
      code = CHAR_LF;
    else if (pick < 22)
      code = CHAR_CR;
    else if (pick < 32)
      code = CHAR_TAB;
    else
      code = 8'($urandom_range(0, 255));
    send_word(code, $urandom_range(0, 11) == 0);
  endtask

  initial begin
    int phase;
    int col;
    int row;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    want_hold = 1'b0;
    draining = 1'b0;
    burst_left = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // out-of-range start column, bottom row
    set_mode(1'b1, 1'b0, 31, 7);
    send_word(8'h41, 1'b1);
    send_word(CHAR_LF, 1'b0);   // swallowed after the wrap
    send_word(CHAR_LF, 1'b0);
    send_word(8'h42, 1'b0);
    repeat (6) send_word(CHAR_TAB, 1'b0);
    send_word(CHAR_CR, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    // enough line feeds to saturate the scroll count
    repeat (9) send_word(CHAR_LF, 1'b0);
    quiesce();
    reg_write(REG_SCROLL_MODE, 32'd0);
    send_word(8'h43, 1'b0);
    quiesce();
    reg_write(REG_SCROLL_MODE, 32'd1);
    reg_write(REG_CONTINUOUS, 32'd1);
    send_word(8'h44, 1'b1);

    for (phase = 0; phase < PHASES; phase++) begin
      quiesce();
      case (phase % 4)
        0: col = 0;
        1: col = 20;
        2: col = $urandom_range(21, 31);
        default: col = $urandom_range(0, 31);
      endcase
      row = (phase % 2 == 0) ? 7 : $urandom_range(0, 7);
      set_mode(phase % 3 != 2, phase % 2 == 1, col, row);
      if (phase == 3)
        want_hold = 1'b1;
      repeat (ITEMS / PHASES) send_random_char();
    end

    in_valid <= 1'b0;
    draining = 1'b1;
    while (words_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatch_count == 0)
      $display("tb_text_console_cursor_engine_unit: done, clean");
    else
      $display("tb_text_console_cursor_engine_unit: done, errors");
    $finish;
  end

endmodule
